### src/kse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kse_pkg
// Shared types, codes and helpers of the kinetic scroll engine.
// ----------------------------------------------------------------------------
package kse_pkg;

  localparam int KSE_FRAC_BITS       = 8;
  localparam int KSE_EXP_TABLE_DEPTH = 64;

  typedef enum logic [2:0] {
    OP_SCROLL_BY  = 3'd0,
    OP_SET_OFFSET = 3'd1,
    OP_FLING      = 3'd2,
    OP_STOP       = 3'd3,
    OP_TICK       = 3'd4,
    OP_BAR_DRAG   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_SPAN_X    = 3'd0,
    REG_SPAN_Y    = 3'd1,
    REG_START_INS = 3'd2,
    REG_END_INS   = 3'd3,
    REG_OVER      = 3'd4,
    REG_SLIP      = 3'd5,
    REG_NATURAL   = 3'd6
  } reg_idx_t;

  localparam longint Q30_ONE      = 64'sd1073741824;
  localparam longint EXP_M1_Q30   = 64'sd395007542;

  // Saturate a wide offset to the 24-bit signed range.
  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v < -28'sd8388608) r = -24'sd8388608;
    else if (v > 28'sd8388607) r = 24'sd8388607;
    else r = v[23:0];
    return r;
  endfunction

  // Shift-subtract division, used only while building constant tables.
  function automatic longint udiv64(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'sd1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // Sample i of exp(-16*i/depth) in Q30.
  function automatic longint exp_entry(input int i, input int depth);
    longint num;
    longint whole;
    longint rem;
    longint f;
    longint sum;
    longint term;
    longint e;
    num   = 64'(16 * i);
    whole = 0;
    rem   = num;
    while (rem >= longint'(depth)) begin
      rem   = rem - longint'(depth);
      whole = whole + 1;
    end
    f    = udiv64(rem << 30, longint'(depth));
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * f) >>> 30, longint'(k));
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    e = sum;
    for (longint j = 0; j < whole; j++) begin
      e = (e * EXP_M1_Q30 + (64'sd1 <<< 29)) >>> 30;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

### src/kse_exp_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kse_exp_rom
// Constant table of exp(-16*i/DEPTH) in Q30, two adjacent samples per read.
// ----------------------------------------------------------------------------
module kse_exp_rom
  import kse_pkg::*;
#(
  parameter int DEPTH = KSE_EXP_TABLE_DEPTH,
  parameter int IW    = $clog2(DEPTH + 1)
) (
  input  wire logic [IW-1:0] idx,
  output logic [30:0]        smp_a,
  output logic [30:0]        smp_b
);

  function automatic logic [DEPTH:0][30:0] build_tab();
    logic [DEPTH:0][30:0] t;
    for (int i = 0; i <= DEPTH; i++) begin
      t[i] = 31'(exp_entry(i, DEPTH));
    end
    return t;
  endfunction

  localparam logic [DEPTH:0][30:0] EXP_TAB = build_tab();

  logic [IW-1:0] idx_b;

  assign idx_b = idx + IW'(1);

  always_comb begin
    smp_a = '0;
    smp_b = '0;
    // Only indexes below DEPTH are ever used by the datapath.
    if (32'(idx) < DEPTH) begin
      smp_a = EXP_TAB[idx];
      smp_b = EXP_TAB[idx_b];
    end
  end

endmodule
`default_nettype wire

### src/kse_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kse_divider
// Restoring divider giving floor((num << 16) / den), one bit per cycle.
// ----------------------------------------------------------------------------
module kse_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [26:0] num,
  input  wire logic [26:0] den,
  output logic             done,
  output logic [15:0]      quo
);

  logic [4:0]  cnt_r, cnt_nxt;
  logic [26:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [27:0] rem2;

  // The remainder stays below den, so the doubled value fits in 28 bits.
  assign rem2 = {rem_r, 1'b0};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num;
      cnt_nxt = 5'd16;
      quo_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem2 >= {1'b0, den}) begin
        rem_nxt = 27'(rem2 - {1'b0, den});
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem2[26:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

### src/kinetic_scroll_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kinetic_scroll_engine
// Two-axis kinetic scroller with fling friction and rubber-band overscroll.
// ----------------------------------------------------------------------------
// Sequencing: a bar drag and each moving axis of a tick go through the shared
// multiplier; the friction table interpolation is skipped when the table
// saturates, and an axis at rest outside the bounds springs back. The bar fraction
// division runs only when the offset lies inside the bounds.
// Throughput: one item at a time; the next item can be taken once the result is
// in the output register, and a new result waits while out_tready is low. All
// multiplies share one 32x18 multiplier; the division uses a bit-serial divider.
// Reset: offsets and velocities clear, registers clear, natural direction set.
module kinetic_scroll_engine
  import kse_pkg::*;
#(
  parameter int FRAC_BITS       = KSE_FRAC_BITS,
  parameter int EXP_TABLE_DEPTH = KSE_EXP_TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // value_x[23:0], value_y[47:24], time_step[63:48], bar_fraction_in[79:64]
  input  wire logic [79:0] in_tdata,
  // op[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // offset_x[23:0], offset_y[47:24], bar_fraction[63:48], scrolling[64],
  // overscrolled[65], zero fill above
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);

  localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic signed [65:0] STOP_TH = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [27:0] SNAP_TH = 28'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_EXEC   = 19'h00002,
    S_FRIC   = 19'h00004,
    S_AX0    = 19'h00008,
    S_MOVE   = 19'h00010,
    S_DAMP   = 19'h00020,
    S_IDX    = 19'h00040,
    S_LUT    = 19'h00080,
    S_L1     = 19'h00100,
    S_L2     = 19'h00200,
    S_L3     = 19'h00400,
    S_V1     = 19'h00800,
    S_V2     = 19'h01000,
    S_V3     = 19'h02000,
    S_SPRING = 19'h04000,
    S_BAR    = 19'h08000,
    S_FRAC   = 19'h10000,
    S_DIV    = 19'h20000,
    S_OUT    = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [23:0] span_x_r, span_y_r, start_r, end_r;
  logic [22:0]        over_r;
  logic [8:0]         slip_r;
  logic               nat_r;

  // Latched item
  op_t                op_r;
  logic signed [23:0] vx_r, vy_r;
  logic [15:0]        dt_r, bf_r;

  // Architectural state
  logic signed [23:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [23:0] spd_x_r, spd_x_nxt, spd_y_r, spd_y_nxt;

  // Working registers
  logic               axis_r, axis_nxt;
  logic signed [20:0] fric_r, fric_nxt;
  logic signed [27:0] o_r, o_nxt;
  logic signed [27:0] bnd_r, bnd_nxt;
  logic [21:0]        damp_r, damp_nxt;
  logic [30:0]        a_r, a_nxt, b_r, b_nxt, e_r, e_nxt;
  logic [19:0]        fr_r, fr_nxt;
  logic signed [49:0] acc_r, acc_nxt;
  logic [15:0]        frac_r, frac_nxt;

  // Shared multiplier
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] prod_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [71:0]        out_data_r, out_data_nxt;

  // Bounds
  logic signed [27:0] lo_x, hi_x, lo_y, hi_y, lim_lo_x, lim_hi_x, lim_lo_y, lim_hi_y;
  logic signed [27:0] hx_raw, hy_raw, ext_y;

  always_comb begin
    lo_x   = -28'(start_r);
    lo_y   = lo_x;
    hx_raw = 28'(span_x_r) + 28'(end_r);
    hy_raw = 28'(span_y_r) + 28'(end_r);
    hi_x   = (hx_raw < lo_x) ? lo_x : hx_raw;
    hi_y   = (hy_raw < lo_y) ? lo_y : hy_raw;
    lim_lo_x = lo_x - 28'(over_r);
    lim_hi_x = hi_x + 28'(over_r);
    lim_lo_y = lo_y - 28'(over_r);
    lim_hi_y = hi_y + 28'(over_r);
    ext_y    = hi_y - lo_y;
  end

  function automatic logic signed [27:0] clamp28(input logic signed [27:0] v,
                                                 input logic signed [27:0] lo,
                                                 input logic signed [27:0] hi);
    logic signed [27:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // Current axis selection
  logic signed [27:0] c_pos, c_lo, c_hi, c_llo, c_lhi;
  logic signed [23:0] c_spd;
  logic [8:0]         slip_c;
  logic [19:0]        k14;
  logic [17:0]        kspr;

  always_comb begin
    c_pos = axis_r ? 28'(pos_y_r) : 28'(pos_x_r);
    c_spd = axis_r ? spd_y_r : spd_x_r;
    c_lo  = axis_r ? lo_y : lo_x;
    c_hi  = axis_r ? hi_y : hi_x;
    c_llo = axis_r ? lim_lo_y : lim_lo_x;
    c_lhi = axis_r ? lim_hi_y : lim_hi_x;
    slip_c = (slip_r > 9'd256) ? 9'd256 : slip_r;
    k14  = {dt_r, 4'b0} - {3'b0, dt_r, 1'b0};
    kspr = (k14 > 20'd65536) ? 18'd65536 : k14[17:0];
  end

  // Exponent table
  logic [30:0] smp_a, smp_b;
  logic [11:0] lut_idx;

  assign lut_idx = prod_r[31:20];

  kse_exp_rom #(
    .DEPTH (EXP_TABLE_DEPTH),
    .IW    (IW)
  ) u_rom (
    .idx   (lut_idx[IW-1:0]),
    .smp_a (smp_a),
    .smp_b (smp_b)
  );

  // Bar fraction divider
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_quo;
  logic signed [27:0] dy;

  assign dy = 28'(pos_y_r) - lo_y;

  kse_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dy[26:0]),
    .den   (ext_y[26:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Temporaries
  logic signed [27:0] nx, ny, o_new, d_snap;
  logic signed [31:0] diff_ab;
  logic signed [55:0] lerp;
  logic signed [65:0] vprod, vn;
  logic signed [21:0] damp_c;
  logic               next_axis;
  logic               ovr;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    spd_x_nxt     = spd_x_r;
    spd_y_nxt     = spd_y_r;
    axis_nxt      = axis_r;
    fric_nxt      = fric_r;
    o_nxt         = o_r;
    bnd_nxt       = bnd_r;
    damp_nxt      = damp_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    fr_nxt        = fr_r;
    acc_nxt       = acc_r;
    frac_nxt      = frac_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    next_axis     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    nx            = '0;
    ny            = '0;
    o_new         = '0;
    d_snap        = '0;
    diff_ab       = 32'(a_r) - 32'(b_r);
    lerp          = '0;
    vprod         = '0;
    vn            = '0;
    damp_c        = '0;
    ovr           = 1'b0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FRAC;
        case (op_r)
          OP_SCROLL_BY, OP_SET_OFFSET: begin
            if (op_r == OP_SET_OFFSET) begin
              nx = 28'(vx_r);
              ny = 28'(vy_r);
            end else if (nat_r) begin
              nx = 28'(pos_x_r) - 28'(vx_r);
              ny = 28'(pos_y_r) - 28'(vy_r);
            end else begin
              nx = 28'(pos_x_r) + 28'(vx_r);
              ny = 28'(pos_y_r) + 28'(vy_r);
            end
            pos_x_nxt = sat24(clamp28(nx, lim_lo_x, lim_hi_x));
            pos_y_nxt = sat24(clamp28(ny, lim_lo_y, lim_hi_y));
          end
          OP_FLING: begin
            spd_x_nxt = vx_r;
            spd_y_nxt = vy_r;
          end
          OP_STOP: begin
            spd_x_nxt = '0;
            spd_y_nxt = '0;
          end
          OP_TICK: begin
            if (dt_r != 16'd0) begin
              mul_a     = 32'sd734003;
              mul_b     = 18'(slip_c);
              state_nxt = S_FRIC;
            end
          end
          OP_BAR_DRAG: begin
            mul_a     = 32'(ext_y);
            mul_b     = 18'(bf_r);
            state_nxt = S_BAR;
          end
          default: state_nxt = S_FRAC;
        endcase
      end
      S_BAR: begin
        pos_y_nxt = sat24(lo_y + 28'((prod_r + 50'sd32768) >>> 16));
        state_nxt = S_FRAC;
      end
      S_FRIC: begin
        fric_nxt  = 21'sd786432 - 21'(prod_r >>> 8);
        axis_nxt  = 1'b0;
        state_nxt = S_AX0;
      end
      S_AX0: begin
        if (c_spd != 24'sd0) begin
          mul_a     = 32'(c_spd);
          mul_b     = 18'(dt_r);
          state_nxt = S_MOVE;
        end else if (c_pos < c_lo || c_pos > c_hi) begin
          bnd_nxt   = (c_pos < c_lo) ? c_lo : c_hi;
          mul_a     = 32'(((c_pos < c_lo) ? c_lo : c_hi) - c_pos);
          mul_b     = kspr;
          state_nxt = S_SPRING;
        end else begin
          next_axis = 1'b1;
        end
      end
      S_MOVE: begin
        o_nxt     = c_pos + 28'((prod_r + 50'sd32768) >>> 16);
        mul_a     = 32'(fric_r);
        mul_b     = 18'(dt_r);
        state_nxt = S_DAMP;
      end
      S_DAMP: begin
        damp_c = 22'(prod_r >>> 16);
        if (o_r < c_lo || o_r > c_hi) begin
          damp_c = damp_c + 22'({dt_r, 2'b0}) + 22'({dt_r, 1'b0});
        end
        damp_nxt  = damp_c;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        mul_a     = 32'(damp_r);
        mul_b     = 18'(EXP_TABLE_DEPTH);
        state_nxt = S_LUT;
      end
      S_LUT: begin
        fr_nxt = prod_r[19:0];
        a_nxt  = smp_a;
        b_nxt  = smp_b;
        if (32'(lut_idx) >= EXP_TABLE_DEPTH) begin
          e_nxt     = '0;
          state_nxt = S_V1;
        end else begin
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        mul_a     = diff_ab;
        mul_b     = 18'(fr_r[19:10]);
        state_nxt = S_L2;
      end
      S_L2: begin
        acc_nxt   = prod_r;
        mul_a     = diff_ab;
        mul_b     = 18'(fr_r[9:0]);
        state_nxt = S_L3;
      end
      S_L3: begin
        lerp      = (56'(acc_r) <<< 10) + 56'(prod_r);
        e_nxt     = 31'(56'(a_r) - (lerp >>> 20));
        state_nxt = S_V1;
      end
      S_V1: begin
        mul_a     = 32'(c_spd);
        mul_b     = 18'(e_r[30:15]);
        state_nxt = S_V2;
      end
      S_V2: begin
        acc_nxt   = prod_r;
        mul_a     = 32'(c_spd);
        mul_b     = 18'(e_r[14:0]);
        state_nxt = S_V3;
      end
      S_V3: begin
        vprod = (66'(acc_r) <<< 15) + 66'(prod_r);
        vn    = (vprod + (66'sd1 <<< 29)) >>> 30;
        if (vn > -STOP_TH && vn < STOP_TH) vn = '0;
        o_new = o_r;
        if (o_r < c_llo) begin
          o_new = c_llo;
          vn    = '0;
        end else if (o_r > c_lhi) begin
          o_new = c_lhi;
          vn    = '0;
        end
        if (axis_r) begin
          pos_y_nxt = sat24(o_new);
          spd_y_nxt = sat24(28'(vn));
        end else begin
          pos_x_nxt = sat24(o_new);
          spd_x_nxt = sat24(28'(vn));
        end
        next_axis = 1'b1;
      end
      S_SPRING: begin
        o_new  = c_pos + 28'((prod_r + 50'sd32768) >>> 16);
        d_snap = bnd_r - o_new;
        if (d_snap > -SNAP_TH && d_snap < SNAP_TH) o_new = bnd_r;
        if (axis_r) pos_y_nxt = sat24(o_new);
        else pos_x_nxt = sat24(o_new);
        next_axis = 1'b1;
      end
      S_FRAC: begin
        state_nxt = S_OUT;
        if (ext_y <= 28'sd0 || dy <= 28'sd0) begin
          frac_nxt = '0;
        end else if (dy >= ext_y) begin
          frac_nxt = 16'hFFFF;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          frac_nxt  = div_quo;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          ovr = (28'(pos_x_r) < lo_x) || (28'(pos_x_r) > hi_x) ||
                (28'(pos_y_r) < lo_y) || (28'(pos_y_r) > hi_y);
          out_data_nxt = {6'b0, ovr, (spd_x_r != 24'sd0) || (spd_y_r != 24'sd0),
                          frac_r, pos_y_r, pos_x_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (next_axis) begin
      if (!axis_r) begin
        axis_nxt  = 1'b1;
        state_nxt = S_AX0;
      end else begin
        state_nxt = S_FRAC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      spd_x_r     <= '0;
      spd_y_r     <= '0;
      axis_r      <= 1'b0;
      span_x_r    <= '0;
      span_y_r    <= '0;
      start_r     <= '0;
      end_r       <= '0;
      over_r      <= '0;
      slip_r      <= '0;
      nat_r       <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      spd_x_r     <= spd_x_nxt;
      spd_y_r     <= spd_y_nxt;
      axis_r      <= axis_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SPAN_X:    span_x_r <= cfg_wdata;
          REG_SPAN_Y:    span_y_r <= cfg_wdata;
          REG_START_INS: start_r  <= cfg_wdata;
          REG_END_INS:   end_r    <= cfg_wdata;
          REG_OVER:      over_r   <= cfg_wdata[22:0];
          REG_SLIP:      slip_r   <= cfg_wdata[8:0];
          REG_NATURAL:   nat_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    if (in_tvalid && in_tready) begin
      op_r <= op_t'(in_tuser);
      vx_r <= in_tdata[23:0];
      vy_r <= in_tdata[47:24];
      dt_r <= in_tdata[63:48];
      bf_r <= in_tdata[79:64];
    end
    fric_r     <= fric_nxt;
    o_r        <= o_nxt;
    bnd_r      <= bnd_nxt;
    damp_r     <= damp_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    e_r        <= e_nxt;
    fr_r       <= fr_nxt;
    acc_r      <= acc_nxt;
    frac_r     <= frac_nxt;
    prod_r     <= 50'(mul_a) * 50'(mul_b);
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
